[rtl/core/sts_pkg.sv]
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types, token codes and keyword tables for the script token scanner.
// ----------------------------------------------------------------------------
package sts_pkg;

  // Longest text run kept for an identifier or string
  localparam int MAX_TEXT = 63;
  localparam int CNT_W    = $clog2(MAX_TEXT + 1);

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Keywords
  localparam int NUM_KW = 7;

  // Token kind codes
  localparam logic [4:0] TK_TEXT   = 5'd0;
  localparam logic [4:0] TK_END    = 5'd1;
  localparam logic [4:0] TK_NUM    = 5'd2;
  localparam logic [4:0] TK_STR    = 5'd3;
  localparam logic [4:0] TK_IDENT  = 5'd4;
  localparam logic [4:0] TK_ASSIGN = 5'd5;
  localparam logic [4:0] TK_EQEQ   = 5'd6;
  localparam logic [4:0] TK_NEQ    = 5'd7;
  localparam logic [4:0] TK_LT     = 5'd8;
  localparam logic [4:0] TK_GT     = 5'd9;
  localparam logic [4:0] TK_LE     = 5'd10;
  localparam logic [4:0] TK_GE     = 5'd11;
  localparam logic [4:0] TK_PLUS   = 5'd12;
  localparam logic [4:0] TK_MINUS  = 5'd13;
  localparam logic [4:0] TK_STAR   = 5'd14;
  localparam logic [4:0] TK_SLASH  = 5'd15;
  localparam logic [4:0] TK_SEMI   = 5'd16;
  localparam logic [4:0] TK_LPAREN = 5'd17;
  localparam logic [4:0] TK_RPAREN = 5'd18;
  localparam logic [4:0] TK_LBRACE = 5'd19;
  localparam logic [4:0] TK_RBRACE = 5'd20;
  localparam logic [4:0] TK_COMMA  = 5'd21;
  localparam logic [4:0] TK_KW0    = 5'd22;
  localparam logic [4:0] TK_BAD    = 5'd29;

  // Scanner modes
  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_COMMENT = 4'd1,
    M_NUMBER  = 4'd2,
    M_IDENT   = 4'd3,
    M_STRING  = 4'd4,
    M_ESCAPE  = 4'd5,
    M_EQ      = 4'd6,
    M_BANG    = 4'd7,
    M_LT      = 4'd8,
    M_GT      = 4'd9,
    M_SLASH   = 4'd10
  } scan_mode_t;

  // Input transaction
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_source;
  } tok_in_t;

  // Result transaction
  typedef struct packed {
    logic [4:0]         token_kind;
    logic signed [31:0] number_value;
    logic [7:0]         text_char;
    logic [5:0]         text_length;
    logic               last_of_run;
  } tok_out_t;

  // Results of one input item, handed to the result queue
  typedef struct packed {
    logic [1:0]         count;
    tok_out_t [1:0]     item;
  } tok_push_t;

  // Keyword spelling, first character in the low byte (strings stored reversed):
  // var print if else while return func
  localparam logic [47:0] KW_TEXT [NUM_KW] = '{
    48'("rav"), 48'("tnirp"), 48'("fi"), 48'("esle"),
    48'("elihw"), 48'("nruter"), 48'("cnuf")
  };
  localparam int KW_LEN [NUM_KW] = '{3, 5, 2, 4, 5, 6, 4};

  // Character of keyword k at position pos (pos below the keyword length)
  function automatic logic [7:0] kw_char(input int k, input logic [2:0] pos);
    logic [47:0] word;
    word = KW_TEXT[k];
    return word[8*pos +: 8];
  endfunction

  // Build one result
  function automatic tok_out_t mk_tok(input logic [4:0] kind, input logic [31:0] num,
                                      input logic [7:0] ch, input logic [5:0] len);
    tok_out_t t;
    t.token_kind   = kind;
    t.number_value = $signed(num);
    t.text_char    = ch;
    t.text_length  = len;
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  // Closing token of an identifier: keyword if a live candidate has this length
  function automatic tok_out_t ident_tok(input logic [NUM_KW-1:0] cand,
                                         input logic [CNT_W-1:0] cnt);
    logic [4:0] kind;
    kind = TK_IDENT;
    for (int k = 0; k < NUM_KW; k++) begin
      if (cand[k] && int'(cnt) == KW_LEN[k]) begin
        kind = TK_KW0 + 5'(k);
      end
    end
    return mk_tok(kind, 32'd0, 8'd0, (kind == TK_IDENT) ? 6'(cnt) : 6'd0);
  endfunction

endpackage

[rtl/core/sts_scan_core.sv]
// ----------------------------------------------------------------------------
// sts_scan_core
// Scanner state and per-byte decode: turns one source byte into up to two
// results and updates mode, number accumulator, text count and keyword set.
// ----------------------------------------------------------------------------
module sts_scan_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              proc,
  input  sts_pkg::tok_in_t  item,
  output sts_pkg::tok_push_t push
);

  sts_pkg::scan_mode_t          mode, mode_next;
  logic [31:0]                  acc, acc_next;
  logic [sts_pkg::CNT_W-1:0]    cnt, cnt_next;
  logic [sts_pkg::NUM_KW-1:0]   cand, cand_next;

  logic [1:0]                   n;
  sts_pkg::tok_out_t [1:0]      res;
  logic                         do_idle;
  logic                         do_ichar;
  logic [sts_pkg::CNT_W-1:0]    ich_cnt;
  logic [sts_pkg::CNT_W-1:0]    cnt_inc;
  logic [sts_pkg::NUM_KW-1:0]   ich_cand;
  logic [sts_pkg::NUM_KW-1:0]   cand_new;
  logic [7:0]                   c;
  logic [7:0]                   esc;
  logic                         is_digit;
  logic                         is_letter;
  logic                         is_blank;

  assign c         = item.char_code;
  assign is_digit  = (c >= "0") && (c <= "9");
  assign is_letter = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  assign is_blank  = (c == " ") || (c == "\t") || (c == 8'h0D) || (c == "\n");
  assign esc       = (c == "n") ? 8'd10 : (c == "t") ? 8'd9 : c;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= sts_pkg::M_IDLE;
      acc  <= '0;
      cnt  <= '0;
      cand <= '1;
    end else if (proc) begin
      mode <= mode_next;
      acc  <= acc_next;
      cnt  <= cnt_next;
      cand <= cand_next;
    end
  end

  // Byte decode; results are appended in order, at most two
  always_comb begin
    mode_next = mode;
    acc_next  = acc;
    cnt_next  = cnt;
    cand_next = cand;
    n         = 2'd0;
    res       = '0;
    do_idle   = 1'b0;
    do_ichar  = 1'b0;
    ich_cnt   = cnt;
    ich_cand  = cand;
    cand_new  = cand;
    cnt_inc   = cnt;

    if (item.end_of_source) begin
      // flush pending token, then end
      unique case (mode)
        sts_pkg::M_NUMBER: begin
          res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_NUM, acc, 8'd0, 6'd0); n = n + 2'd1;
        end
        sts_pkg::M_IDENT: begin
          res[n[0]] = sts_pkg::ident_tok(cand, cnt); n = n + 2'd1;
        end
        sts_pkg::M_STRING, sts_pkg::M_ESCAPE: begin
          res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_STR, 32'd0, 8'd0, 6'(cnt)); n = n + 2'd1;
        end
        sts_pkg::M_EQ: begin
          res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_ASSIGN, 32'd0, 8'd0, 6'd0); n = n + 2'd1;
        end
        sts_pkg::M_BANG: begin
          res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_BAD, 32'd0, 8'd0, 6'd0); n = n + 2'd1;
        end
        sts_pkg::M_LT: begin
          res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_LT, 32'd0, 8'd0, 6'd0); n = n + 2'd1;
        end
        sts_pkg::M_GT: begin
          res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_GT, 32'd0, 8'd0, 6'd0); n = n + 2'd1;
        end
        sts_pkg::M_SLASH: begin
          res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_SLASH, 32'd0, 8'd0, 6'd0); n = n + 2'd1;
        end
        default: ;
      endcase
      if (n < 2'd2) begin
        res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_END, 32'd0, 8'd0, 6'd0); n = n + 2'd1;
      end
      mode_next = sts_pkg::M_IDLE;
      acc_next  = '0;
      cnt_next  = '0;
      cand_next = '1;
    end else begin
      // mode-specific handling
      unique case (mode)
        sts_pkg::M_COMMENT: begin
          if (c == "\n") mode_next = sts_pkg::M_IDLE;
        end
        sts_pkg::M_NUMBER: begin
          if (is_digit) begin
            acc_next = (acc << 3) + (acc << 1) + {24'd0, c - "0"};
          end else begin
            res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_NUM, acc, 8'd0, 6'd0); n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        sts_pkg::M_IDENT: begin
          if (is_letter || is_digit) begin
            do_ichar = 1'b1;
          end else begin
            res[n[0]] = sts_pkg::ident_tok(cand, cnt); n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        sts_pkg::M_STRING: begin
          if (c == "\"") begin
            res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_STR, 32'd0, 8'd0, 6'(cnt)); n = n + 2'd1;
            mode_next = sts_pkg::M_IDLE;
          end else if (c == "\\") begin
            mode_next = sts_pkg::M_ESCAPE;
          end else if (int'(cnt) < sts_pkg::MAX_TEXT) begin
            res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_TEXT, 32'd0, c, 6'd0); n = n + 2'd1;
            cnt_next = cnt + 1'b1;
          end
        end
        sts_pkg::M_ESCAPE: begin
          if (int'(cnt) < sts_pkg::MAX_TEXT) begin
            res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_TEXT, 32'd0, esc, 6'd0); n = n + 2'd1;
            cnt_next = cnt + 1'b1;
          end
          mode_next = sts_pkg::M_STRING;
        end
        sts_pkg::M_EQ: begin
          if (c == "=") begin
            res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_EQEQ, 32'd0, 8'd0, 6'd0); n = n + 2'd1;
            mode_next = sts_pkg::M_IDLE;
          end else begin
            res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_ASSIGN, 32'd0, 8'd0, 6'd0); n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        sts_pkg::M_BANG: begin
          if (c == "=") begin
            res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_NEQ, 32'd0, 8'd0, 6'd0); n = n + 2'd1;
            mode_next = sts_pkg::M_IDLE;
          end else begin
            res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_BAD, 32'd0, 8'd0, 6'd0); n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        sts_pkg::M_LT: begin
          if (c == "=") begin
            res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_LE, 32'd0, 8'd0, 6'd0); n = n + 2'd1;
            mode_next = sts_pkg::M_IDLE;
          end else begin
            res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_LT, 32'd0, 8'd0, 6'd0); n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        sts_pkg::M_GT: begin
          if (c == "=") begin
            res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_GE, 32'd0, 8'd0, 6'd0); n = n + 2'd1;
            mode_next = sts_pkg::M_IDLE;
          end else begin
            res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_GT, 32'd0, 8'd0, 6'd0); n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        sts_pkg::M_SLASH: begin
          if (c == "/") begin
            mode_next = sts_pkg::M_COMMENT;
          end else begin
            res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_SLASH, 32'd0, 8'd0, 6'd0); n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase

      // fresh byte scanned from idle
      if (do_idle) begin
        mode_next = sts_pkg::M_IDLE;
        if (is_blank) begin
          mode_next = sts_pkg::M_IDLE;
        end else if (is_digit) begin
          mode_next = sts_pkg::M_NUMBER;
          acc_next  = {24'd0, c - "0"};
        end else if (is_letter) begin
          mode_next = sts_pkg::M_IDENT;
          do_ichar  = 1'b1;
          ich_cnt   = '0;
          ich_cand  = '1;
        end else begin
          unique case (c)
            "#":  mode_next = sts_pkg::M_COMMENT;
            "\"": begin
              mode_next = sts_pkg::M_STRING;
              cnt_next  = '0;
            end
            "/":  mode_next = sts_pkg::M_SLASH;
            "=":  mode_next = sts_pkg::M_EQ;
            "!":  mode_next = sts_pkg::M_BANG;
            "<":  mode_next = sts_pkg::M_LT;
            ">":  mode_next = sts_pkg::M_GT;
            "+": begin
              res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_PLUS, 32'd0, 8'd0, 6'd0); n = n + 2'd1;
            end
            "-": begin
              res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_MINUS, 32'd0, 8'd0, 6'd0); n = n + 2'd1;
            end
            "*": begin
              res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_STAR, 32'd0, 8'd0, 6'd0); n = n + 2'd1;
            end
            ";": begin
              res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_SEMI, 32'd0, 8'd0, 6'd0); n = n + 2'd1;
            end
            "(": begin
              res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_LPAREN, 32'd0, 8'd0, 6'd0); n = n + 2'd1;
            end
            ")": begin
              res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_RPAREN, 32'd0, 8'd0, 6'd0); n = n + 2'd1;
            end
            "{": begin
              res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_LBRACE, 32'd0, 8'd0, 6'd0); n = n + 2'd1;
            end
            "}": begin
              res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_RBRACE, 32'd0, 8'd0, 6'd0); n = n + 2'd1;
            end
            ",": begin
              res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_COMMA, 32'd0, 8'd0, 6'd0); n = n + 2'd1;
            end
            default: begin
              res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_BAD, 32'd0, 8'd0, 6'd0); n = n + 2'd1;
            end
          endcase
        end
      end

      // identifier character: prune keywords, echo, split at the text limit
      if (do_ichar) begin
        for (int k = 0; k < sts_pkg::NUM_KW; k++) begin
          cand_new[k] = ich_cand[k] && (int'(ich_cnt) < sts_pkg::KW_LEN[k]) &&
                        (sts_pkg::kw_char(k, 3'(int'(ich_cnt))) == c);
        end
        if (n < 2'd2) begin
          res[n[0]] = sts_pkg::mk_tok(sts_pkg::TK_TEXT, 32'd0, c, 6'd0); n = n + 2'd1;
        end
        cnt_inc   = ich_cnt + 1'b1;
        cnt_next  = cnt_inc;
        cand_next = cand_new;
        if (int'(cnt_inc) >= sts_pkg::MAX_TEXT) begin
          if (n < 2'd2) begin
            res[n[0]] = sts_pkg::ident_tok(cand_new, cnt_inc); n = n + 2'd1;
          end
          mode_next = sts_pkg::M_IDLE;
        end
      end
    end

    // mark the final result of this item
    if (n == 2'd2) begin
      res[1].last_of_run = 1'b1;
    end else if (n == 2'd1) begin
      res[0].last_of_run = 1'b1;
    end
  end

  assign push.count = proc ? n : 2'd0;
  assign push.item  = res;

endmodule

[rtl/core/sts_result_fifo.sv]
// ----------------------------------------------------------------------------
// sts_result_fifo
// Small result queue: takes up to two results per cycle, delivers one per
// transaction on the output channel.
// ----------------------------------------------------------------------------
module sts_result_fifo (
  input  logic               clk,
  input  logic               rst,
  input  sts_pkg::tok_push_t push,
  output logic               room,
  output logic               valid,
  input  logic               stall,
  output sts_pkg::tok_out_t  item
);

  sts_pkg::tok_out_t               mem [sts_pkg::FIFO_DEPTH];
  logic [sts_pkg::FIFO_PTR_W-1:0]  wr_ptr;
  logic [sts_pkg::FIFO_PTR_W-1:0]  rd_ptr;
  logic [sts_pkg::FIFO_CNT_W-1:0]  count;
  logic                            pop;

  assign valid = (count != '0);
  assign pop   = valid && !stall;
  // room for a full pair of results
  assign room  = (int'(count) <= sts_pkg::FIFO_DEPTH - 2);
  assign item  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.item[0];
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + 1'b1] <= push.item[1];
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + sts_pkg::FIFO_PTR_W'(push.count);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count  <= count + sts_pkg::FIFO_CNT_W'(push.count) - sts_pkg::FIFO_CNT_W'(pop);
    end
  end

endmodule

[rtl/core/script_token_scanner.sv]
// ----------------------------------------------------------------------------
// script_token_scanner
// Streaming tokenizer: one source byte (or end mark) per input transaction,
// text characters and tokens out, one result per output transaction.
// ----------------------------------------------------------------------------
//  channel  | payload             | handshake           | per transaction
//  src      | sts_pkg::tok_in_t   | src_valid/src_stall | one byte or end mark
//  tok      | sts_pkg::tok_out_t  | tok_valid/tok_stall | one result
//
//  One byte per cycle while the queue has room: the byte register feeds the
//  scanner decode, whose 0 to 2 results land in a 4-entry result queue the
//  next edge. A byte is held in the byte register, and its results in the
//  result queue, before the first of them can leave.
//  A byte waits in the register while the queue has fewer than two free slots;
//  src_stall is high exactly then. Output stalls only hold the queue.
//  rst clears scanner state and empties the byte register and the queue.
// ----------------------------------------------------------------------------
module script_token_scanner (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_stall,
  input  sts_pkg::tok_in_t  src_item,
  output logic              tok_valid,
  input  logic              tok_stall,
  output sts_pkg::tok_out_t tok_item
);

  sts_pkg::tok_in_t   in_q;
  logic               in_full;
  logic               room;
  logic               proc;
  logic               take;
  sts_pkg::tok_push_t push;

  // Byte register: advances into the decode when the queue has room
  assign proc      = in_full && room;
  assign src_stall = in_full && !room;
  assign take      = src_valid && !src_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take) begin
      in_full <= 1'b1;
    end else if (proc) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) in_q <= src_item;
  end

  sts_scan_core u_core (
    .clk  (clk),
    .rst  (rst),
    .proc (proc),
    .item (in_q),
    .push (push)
  );

  sts_result_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .room  (room),
    .valid (tok_valid),
    .stall (tok_stall),
    .item  (tok_item)
  );

endmodule
